[rtl/core/usbmidi_pkg.sv]
// Shared types and constants for the USB-MIDI event packet encoder.
// Used by usbmidi_front, usbmidi_queue, usbmidi_back and the core top level.
// No dependencies.
package usbmidi_pkg;

   localparam int unsigned QueueDepthDefault = 2;

   localparam logic [7:0] SYSEX_START = 8'hF0;

   localparam logic [3:0] CODE_SX_CONT  = 4'h4;
   localparam logic [3:0] CODE_SX_ONE   = 4'h5;
   localparam logic [3:0] CODE_SX_TWO   = 4'h6;
   localparam logic [3:0] CODE_SX_THREE = 4'h7;
   localparam logic [3:0] CODE_SYSTEM   = 4'h2;

   // Bytes held in a finished group, 1..3
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   // One finished group, ready to be formatted into a packet
   typedef struct packed {
      logic [7:0] lead;
      logic [7:0] middle;
      logic [7:0] third;
      logic [1:0] count;
      logic       exclusive;
      logic       last;
   } job_type;

endpackage

[rtl/core/usb_midi_packet_encoder_core.sv]
// Top level of the USB-MIDI event packet encoder (cable number zero).
// Instantiates usbmidi_front, usbmidi_queue and usbmidi_back; uses usbmidi_pkg.
//
// Feed raw MIDI bytes of a message buffer one per item on req_, with req_tlast
// on the buffer's final byte; the core emits 4-byte USB-MIDI event packets on
// rsp_, one per group of three bytes and one for any short group at buffer end.
// A group led by 0xF0 switches to system-exclusive codes (4, 5, 6, 7) until the
// buffer ends; other groups use status>>4, or 2 for 0xF1 and above. Unused
// payload bytes are zero and rsp_tlast marks the packet that ends the buffer.
// The core takes one byte per cycle while the queue has room; the back end
// never limits that rate unless rsp_ is stalled. A finished group is written
// into a queue slot and then popped into the back end's output register. The
// queue of QUEUE_DEPTH groups lets the front keep accepting while rsp_ is
// stalled; req_tready drops only once the queue is full. There is no
// configuration.
module usb_midi_packet_encoder_core #(
   parameter int unsigned QUEUE_DEPTH = usbmidi_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // MIDI byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] midi_byte
   input  logic        req_tlast,   // buffer_end
   // event packet stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] code_index, [11:4] first_byte,
                                    // [19:12] second_byte, [27:20] third_byte, [31:28] zero
   output logic        rsp_tlast    // final_packet
);

   usbmidi_pkg::job_type push_job;
   usbmidi_pkg::job_type pop_job;
   logic push, pop, queue_full, queue_empty;

   // Front: group bytes, track sysex mode, push finished groups
   usbmidi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Decouple front and back so each side can stall on its own
   usbmidi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_job  (pop_job)
   );

   // Back: pick code index, hold packet in the output register
   usbmidi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

[rtl/core/usbmidi_front.sv]
// Front end: accepts MIDI bytes, groups them in threes and tracks sysex mode.
// Pushes one finished group per packet into the queue. Depends on usbmidi_pkg.
module usbmidi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 queue_full,
   output logic                 push,
   output usbmidi_pkg::job_type push_job
);

   logic [7:0] lead_ff, lead_in;
   logic [7:0] middle_ff, middle_in;
   logic [1:0] fill_ff, fill_in;
   logic       excl_ff, excl_in;

   logic       accept;
   logic       excl_now;
   logic [1:0] cnt;
   logic       emit;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      // only the first byte of a group can open sysex mode
      excl_now = excl_ff || (fill_ff == 2'd0 && in_byte == usbmidi_pkg::SYSEX_START);
      cnt      = fill_ff + 2'd1;
      push_job.exclusive = excl_now;
      push_job.last      = in_last;
      push_job.count     = cnt;
      case (fill_ff)
         2'd0: begin
            push_job.lead   = in_byte;
            push_job.middle = 8'd0;
            push_job.third  = 8'd0;
         end
         2'd1: begin
            push_job.lead   = lead_ff;
            push_job.middle = in_byte;
            push_job.third  = 8'd0;
         end
         default: begin
            push_job.lead   = lead_ff;
            push_job.middle = middle_ff;
            push_job.third  = in_byte;
         end
      endcase
      emit = (cnt == usbmidi_pkg::COUNT_THREE) || in_last;
      push = accept && emit;

      lead_in   = lead_ff;
      middle_in = middle_ff;
      fill_in   = fill_ff;
      excl_in   = excl_ff;
      if (accept) begin
         if (emit) begin
            fill_in   = 2'd0;
            lead_in   = 8'd0;
            middle_in = 8'd0;
            excl_in   = in_last ? 1'b0 : excl_now;
         end else begin
            fill_in = cnt;
            excl_in = excl_now;
            if (cnt == usbmidi_pkg::COUNT_ONE) begin
               lead_in = in_byte;
            end else begin
               middle_in = in_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff   <= 8'd0;
         middle_ff <= 8'd0;
         fill_ff   <= 2'd0;
         excl_ff   <= 1'b0;
      end else begin
         lead_ff   <= lead_in;
         middle_ff <= middle_in;
         fill_ff   <= fill_in;
         excl_ff   <= excl_in;
      end
   end

   a_fill_below_three: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("open group holds three bytes");

   a_end_clears_group: assert property (@(posedge clock) disable iff (reset)
      (accept && in_last) |=> (fill_ff == 2'd0 && !excl_ff))
      else $error("buffer end left group or sysex mode open");

   a_full_group_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && fill_ff == 2'd2) |-> push)
      else $error("third byte did not push a packet");

endmodule

[rtl/core/usbmidi_queue.sv]
// Short queue of finished groups between front and back end.
// Depends on usbmidi_pkg for the job type.
module usbmidi_queue #(
   parameter int unsigned DEPTH = usbmidi_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  usbmidi_pkg::job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output usbmidi_pkg::job_type pop_job
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   usbmidi_pkg::job_type slot_ff [DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == FullCnt);
   assign empty   = (cnt_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FullCnt)
      else $error("queue count beyond depth");

   a_push_only_with_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_pop_only_with_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

[rtl/core/usbmidi_back.sv]
// Back end: pops finished groups, picks the code index and registers the packet.
// Depends on usbmidi_pkg.
module usbmidi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  usbmidi_pkg::job_type pop_job,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [31:0]          out_data,
   output logic                 out_last
);

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic [3:0]  code;

   assign pop       = !queue_empty && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

   always_comb begin
      if (pop_job.exclusive) begin
         case (pop_job.count)
            usbmidi_pkg::COUNT_THREE:
               code = pop_job.last ? usbmidi_pkg::CODE_SX_THREE : usbmidi_pkg::CODE_SX_CONT;
            usbmidi_pkg::COUNT_TWO: code = usbmidi_pkg::CODE_SX_TWO;
            default:                code = usbmidi_pkg::CODE_SX_ONE;
         endcase
      end else if (pop_job.lead > usbmidi_pkg::SYSEX_START) begin
         code = usbmidi_pkg::CODE_SYSTEM;
      end else begin
         code = pop_job.lead[7:4];
      end

      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = {4'd0, pop_job.third, pop_job.middle, pop_job.lead, code};
         last_in  = pop_job.last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("popped group not presented");

   a_no_pop_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |-> !pop)
      else $error("popped over a stalled packet");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff[31:28] == 4'd0)
      else $error("packet padding not zero");

endmodule
